// File: rtl/tpve_pkg.sv
// shared types, codes and constants of the three point velocity estimator
`default_nettype none

package tpve_pkg;

    localparam int WINDOW_DEF   = 3;
    localparam int HIST         = 3;
    localparam int LANES        = 4;

    localparam int TS_W         = 32;
    localparam int SWA_W        = 19;
    localparam int JA_W         = 32;
    localparam int VEL_W        = 22;
    localparam int MAXV_W       = 21;
    localparam int MINI_W       = 16;
    localparam int DIFF_W       = 33;
    localparam int SWD_W        = 21;
    localparam int MAG_W        = 32;
    localparam int NUM_W        = 52;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 21;

    localparam logic [MAXV_W-1:0] MAXV_RESET = 21'd34315;
    localparam logic [MINI_W-1:0] MINI_RESET = 16'd1;

    localparam logic signed [SWD_W-1:0] PI_Q     = 21'sd205887;
    localparam logic signed [SWD_W-1:0] TWO_PI_Q = 21'sd411775;
    localparam logic [19:0]             US_PER_S = 20'd1000000;

    localparam logic [1:0] FUNC_SWING = 2'd0;
    localparam logic [1:0] FUNC_JOINT = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL_US = 2'd1;

    localparam int LANE_SWING  = 0;
    localparam int LANE_BOOM   = 1;
    localparam int LANE_ARM    = 2;
    localparam int LANE_BUCKET = 3;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_MUL,
        LN_DIV,
        LN_FIN
    } lane_state_t;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_START,
        CT_WAIT
    } ctrl_state_t;

    typedef struct packed {
        logic                    done;
        logic signed [VEL_W-1:0] vel;
    } lane_res_t;

endpackage

`default_nettype wire

// File: rtl/tpve_lane.sv
// one velocity lane: scale by 1e6, serial restoring divide by dt, clamp and sign
`default_nettype none

module tpve_lane (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic                                   take,
    input  wire logic signed [tpve_pkg::DIFF_W-1:0]     diff,
    input  wire logic        [tpve_pkg::TS_W-1:0]       dt,
    input  wire logic                                   enable,
    input  wire logic        [tpve_pkg::MAXV_W-1:0]     max_velocity,
    output tpve_pkg::lane_res_t                         res
);

    localparam int NUM_W = tpve_pkg::NUM_W;
    localparam int CNT_W = $clog2(NUM_W);

    tpve_pkg::lane_state_t state_reg, state_next;

    logic [CNT_W-1:0]               cnt_reg;
    logic                           neg_reg;
    logic                           en_reg;
    logic [tpve_pkg::MAG_W-1:0]     mag_reg;
    logic [tpve_pkg::TS_W-1:0]      dt_reg;
    logic [NUM_W-1:0]               prod_reg;
    logic [tpve_pkg::TS_W-1:0]      rem_reg;
    logic [tpve_pkg::VEL_W-1:0]     quo_reg;
    logic                           ovf_reg;

    logic [tpve_pkg::TS_W:0]        rem_sh;
    logic                           ge;
    logic [tpve_pkg::TS_W-1:0]      rem_next;
    logic                           last_step;
    logic                           sat;
    logic [tpve_pkg::VEL_W-1:0]     mag_out;
    logic [tpve_pkg::DIFF_W-1:0]    diff_neg;

    assign rem_sh    = {rem_reg, prod_reg[NUM_W-1]};
    assign ge        = rem_sh >= {1'b0, dt_reg};
    assign rem_next  = ge ? tpve_pkg::TS_W'(rem_sh - {1'b0, dt_reg})
                          : rem_sh[tpve_pkg::TS_W-1:0];
    assign last_step = cnt_reg == CNT_W'(NUM_W - 1);
    assign diff_neg  = -diff;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpve_pkg::LN_IDLE:
            begin
                if (start)
                begin
                    state_next = tpve_pkg::LN_MUL;
                end
            end
            tpve_pkg::LN_MUL:
            begin
                state_next = tpve_pkg::LN_DIV;
            end
            tpve_pkg::LN_DIV:
            begin
                if (last_step)
                begin
                    state_next = tpve_pkg::LN_FIN;
                end
            end
            tpve_pkg::LN_FIN:
            begin
                if (take)
                begin
                    state_next = tpve_pkg::LN_IDLE;
                end
            end
            default:
            begin
                state_next = tpve_pkg::LN_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        sat      = ovf_reg || (quo_reg > {1'b0, max_velocity});
        mag_out  = sat ? {1'b0, max_velocity} : quo_reg;
        res.done = state_reg == tpve_pkg::LN_FIN;
        if (!en_reg)
        begin
            res.vel = '0;
        end
        else if (neg_reg)
        begin
            res.vel = -$signed(mag_out);
        end
        else
        begin
            res.vel = $signed(mag_out);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpve_pkg::LN_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tpve_pkg::LN_DIV)
            begin
                cnt_reg <= last_step ? '0 : cnt_reg + CNT_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tpve_pkg::LN_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= diff[tpve_pkg::DIFF_W-1];
                    mag_reg <= diff[tpve_pkg::DIFF_W-1]
                               ? diff_neg[tpve_pkg::MAG_W-1:0]
                               : diff[tpve_pkg::MAG_W-1:0];
                    dt_reg  <= dt;
                    en_reg  <= enable;
                end
            end
            tpve_pkg::LN_MUL:
            begin
                prod_reg <= NUM_W'(mag_reg) * NUM_W'(tpve_pkg::US_PER_S);
                rem_reg  <= '0;
                quo_reg  <= '0;
                ovf_reg  <= 1'b0;
            end
            tpve_pkg::LN_DIV:
            begin
                prod_reg <= {prod_reg[NUM_W-2:0], 1'b0};
                rem_reg  <= rem_next;
                quo_reg  <= {quo_reg[tpve_pkg::VEL_W-2:0], ge};
                ovf_reg  <= ovf_reg | quo_reg[tpve_pkg::VEL_W-1];
            end
            tpve_pkg::LN_FIN:
            begin
                prod_reg <= prod_reg;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == tpve_pkg::LN_IDLE)
        else $error("lane started while busy");

    a_take_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> res.done)
        else $error("lane result taken before it was ready");

    a_fin_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.done) |-> $past(state_reg) == tpve_pkg::LN_DIV)
        else $error("lane finished without a full divide");

endmodule

`default_nettype wire

// File: rtl/tpve_merge.sv
// merging stage: gathers the lane results into the result register
`default_nettype none

module tpve_merge (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire tpve_pkg::lane_res_t [tpve_pkg::LANES-1:0]  lane_res,
    input  wire logic                                       result_stall,
    output logic                                            take,
    output logic                                            result_valid,
    output logic signed [tpve_pkg::VEL_W-1:0]               swing_velocity,
    output logic signed [tpve_pkg::VEL_W-1:0]               boom_velocity,
    output logic signed [tpve_pkg::VEL_W-1:0]               arm_velocity,
    output logic signed [tpve_pkg::VEL_W-1:0]               bucket_velocity
);

    logic                         valid_reg, valid_next;
    logic [tpve_pkg::LANES-1:0]   done_vec;
    logic signed [tpve_pkg::VEL_W-1:0] vel_reg [tpve_pkg::LANES];

    always_comb
    begin
        for (int i = 0; i < tpve_pkg::LANES; i++)
        begin
            done_vec[i] = lane_res[i].done;
        end
    end

    assign take = (&done_vec) && (!valid_reg || !result_stall);

    always_comb
    begin
        priority if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < tpve_pkg::LANES; i++)
            begin
                vel_reg[i] <= lane_res[i].vel;
            end
        end
    end

    assign result_valid    = valid_reg;
    assign swing_velocity  = vel_reg[tpve_pkg::LANE_SWING];
    assign boom_velocity   = vel_reg[tpve_pkg::LANE_BOOM];
    assign arm_velocity    = vel_reg[tpve_pkg::LANE_ARM];
    assign bucket_velocity = vel_reg[tpve_pkg::LANE_BUCKET];

endmodule

`default_nettype wire

// File: rtl/three_point_velocity_estimator_unit.sv
// top level: sample histories, item control, four velocity lanes and the merging stage
//
// The unit takes one item at a time and returns one result per item. The histories
// are updated at the item transfer itself; the control then starts the lanes, and
// each lane loads its operands, does the scaling multiply and the 52-step bit-serial
// restoring divide, and the merging stage moves the result into the output register;
// the four lanes (swing, boom, arm, bucket) run side by side. The next item is taken
// as soon as the result sits in the output register, even if it has not yet been
// transferred; a result stall on a full output register keeps the result in the
// lanes and so holds off the next item. No clearing pass follows reset.
`default_nettype none

module three_point_velocity_estimator_unit #(
    parameter int WINDOW = tpve_pkg::WINDOW_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       item_valid,
    output logic                                            item_stall,
    input  wire logic        [1:0]                          func,
    input  wire logic        [tpve_pkg::TS_W-1:0]           timestamp_us,
    input  wire logic        [tpve_pkg::SWA_W-1:0]          swing_angle,
    input  wire logic signed [tpve_pkg::JA_W-1:0]           boom_angle,
    input  wire logic signed [tpve_pkg::JA_W-1:0]           arm_angle,
    input  wire logic signed [tpve_pkg::JA_W-1:0]           bucket_angle,
    output logic                                            result_valid,
    input  wire logic                                       result_stall,
    output logic signed [tpve_pkg::VEL_W-1:0]               swing_velocity,
    output logic signed [tpve_pkg::VEL_W-1:0]               boom_velocity,
    output logic signed [tpve_pkg::VEL_W-1:0]               arm_velocity,
    output logic signed [tpve_pkg::VEL_W-1:0]               bucket_velocity,
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic        [tpve_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic        [tpve_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int  CNT_W   = $clog2(WINDOW + 1);
    localparam bit  HAS_VEL = WINDOW >= tpve_pkg::HIST;
    localparam int  HIST    = tpve_pkg::HIST;
    localparam int  LANES   = tpve_pkg::LANES;
    localparam int  DIFF_W  = tpve_pkg::DIFF_W;
    localparam int  SWD_W   = tpve_pkg::SWD_W;

    tpve_pkg::ctrl_state_t state_reg, state_next;

    logic [tpve_pkg::MAXV_W-1:0]    max_velocity_reg;
    logic [tpve_pkg::MINI_W-1:0]    min_interval_reg;

    logic [CNT_W-1:0]               swing_cnt_reg, swing_cnt_next;
    logic [CNT_W-1:0]               joint_cnt_reg, joint_cnt_next;

    logic        [tpve_pkg::TS_W-1:0]  st_reg [HIST];
    logic        [tpve_pkg::SWA_W-1:0] sa_reg [HIST];
    logic        [tpve_pkg::TS_W-1:0]  jt_reg [HIST];
    logic signed [tpve_pkg::JA_W-1:0]  jb_reg [HIST];
    logic signed [tpve_pkg::JA_W-1:0]  ja_reg [HIST];
    logic signed [tpve_pkg::JA_W-1:0]  jk_reg [HIST];

    logic                           item_xfer;
    logic                           lane_start;
    logic                           take;

    logic [tpve_pkg::TS_W-1:0]      dt_s, dt_j;
    logic signed [SWD_W-1:0]        sd0, sd1, sd2;
    logic                           en_s, en_j;

    logic signed [DIFF_W-1:0]       lane_diff [LANES];
    logic [tpve_pkg::TS_W-1:0]      lane_dt   [LANES];
    logic                           lane_en   [LANES];
    tpve_pkg::lane_res_t [LANES-1:0] lane_res;

    assign item_xfer = item_valid && !item_stall;
    assign cfg_ready = 1'b1;

    // control: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpve_pkg::CT_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = tpve_pkg::CT_START;
                end
            end
            tpve_pkg::CT_START:
            begin
                state_next = tpve_pkg::CT_WAIT;
            end
            tpve_pkg::CT_WAIT:
            begin
                if (take)
                begin
                    state_next = tpve_pkg::CT_IDLE;
                end
            end
            default:
            begin
                state_next = tpve_pkg::CT_IDLE;
            end
        endcase
    end

    // control: outputs
    always_comb
    begin
        item_stall = state_reg != tpve_pkg::CT_IDLE;
        lane_start = state_reg == tpve_pkg::CT_START;
    end

    // history counts
    always_comb
    begin
        swing_cnt_next = swing_cnt_reg;
        joint_cnt_next = joint_cnt_reg;
        if (item_xfer)
        begin
            unique case (func)
                tpve_pkg::FUNC_SWING:
                begin
                    if (swing_cnt_reg != CNT_W'(WINDOW))
                    begin
                        swing_cnt_next = swing_cnt_reg + CNT_W'(1);
                    end
                end
                tpve_pkg::FUNC_JOINT:
                begin
                    if (joint_cnt_reg != CNT_W'(WINDOW))
                    begin
                        joint_cnt_next = joint_cnt_reg + CNT_W'(1);
                    end
                end
                tpve_pkg::FUNC_CLEAR:
                begin
                    swing_cnt_next = '0;
                    joint_cnt_next = '0;
                end
                default:
                begin
                    swing_cnt_next = swing_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tpve_pkg::CT_IDLE;
            swing_cnt_reg    <= '0;
            joint_cnt_reg    <= '0;
            max_velocity_reg <= tpve_pkg::MAXV_RESET;
            min_interval_reg <= tpve_pkg::MINI_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            swing_cnt_reg <= swing_cnt_next;
            joint_cnt_reg <= joint_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tpve_pkg::REG_MAX_VELOCITY)
                begin
                    max_velocity_reg <= cfg_data;
                end
                if (cfg_index == tpve_pkg::REG_MIN_INTERVAL_US)
                begin
                    min_interval_reg <= cfg_data[tpve_pkg::MINI_W-1:0];
                end
            end
        end
    end

    // sample histories, newest at tap zero
    always_ff @(posedge clk)
    begin
        if (item_xfer && func == tpve_pkg::FUNC_SWING)
        begin
            st_reg[0] <= timestamp_us;
            sa_reg[0] <= swing_angle;
            for (int i = 1; i < HIST; i++)
            begin
                st_reg[i] <= st_reg[i-1];
                sa_reg[i] <= sa_reg[i-1];
            end
        end
        if (item_xfer && func == tpve_pkg::FUNC_JOINT)
        begin
            jt_reg[0] <= timestamp_us;
            jb_reg[0] <= boom_angle;
            ja_reg[0] <= arm_angle;
            jk_reg[0] <= bucket_angle;
            for (int i = 1; i < HIST; i++)
            begin
                jt_reg[i] <= jt_reg[i-1];
                jb_reg[i] <= jb_reg[i-1];
                ja_reg[i] <= ja_reg[i-1];
                jk_reg[i] <= jk_reg[i-1];
            end
        end
    end

    // differences between newest and third-newest sample
    always_comb
    begin
        dt_s = st_reg[0] - st_reg[HIST-1];
        dt_j = jt_reg[0] - jt_reg[HIST-1];

        sd0 = $signed({2'b00, sa_reg[0]}) - $signed({2'b00, sa_reg[HIST-1]});
        sd1 = (sd0 > tpve_pkg::PI_Q) ? sd0 - tpve_pkg::TWO_PI_Q : sd0;
        sd2 = (sd1 <= -tpve_pkg::PI_Q) ? sd1 + tpve_pkg::TWO_PI_Q : sd1;

        en_s = HAS_VEL && (swing_cnt_reg >= CNT_W'(HIST))
               && (dt_s > {16'b0, min_interval_reg});
        en_j = HAS_VEL && (joint_cnt_reg >= CNT_W'(HIST))
               && (dt_j > {16'b0, min_interval_reg});

        lane_diff[tpve_pkg::LANE_SWING]  = {{(DIFF_W - SWD_W){sd2[SWD_W-1]}}, sd2};
        lane_diff[tpve_pkg::LANE_BOOM]   = {jb_reg[0][31], jb_reg[0]}
                                         - {jb_reg[HIST-1][31], jb_reg[HIST-1]};
        lane_diff[tpve_pkg::LANE_ARM]    = {ja_reg[0][31], ja_reg[0]}
                                         - {ja_reg[HIST-1][31], ja_reg[HIST-1]};
        lane_diff[tpve_pkg::LANE_BUCKET] = {jk_reg[0][31], jk_reg[0]}
                                         - {jk_reg[HIST-1][31], jk_reg[HIST-1]};

        lane_dt[tpve_pkg::LANE_SWING]  = dt_s;
        lane_dt[tpve_pkg::LANE_BOOM]   = dt_j;
        lane_dt[tpve_pkg::LANE_ARM]    = dt_j;
        lane_dt[tpve_pkg::LANE_BUCKET] = dt_j;

        lane_en[tpve_pkg::LANE_SWING]  = en_s;
        lane_en[tpve_pkg::LANE_BOOM]   = en_j;
        lane_en[tpve_pkg::LANE_ARM]    = en_j;
        lane_en[tpve_pkg::LANE_BUCKET] = en_j;
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        tpve_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .start        (lane_start),
            .take         (take),
            .diff         (lane_diff[g]),
            .dt           (lane_dt[g]),
            .enable       (lane_en[g]),
            .max_velocity (max_velocity_reg),
            .res          (lane_res[g])
        );
    end

    tpve_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .lane_res        (lane_res),
        .result_stall    (result_stall),
        .take            (take),
        .result_valid    (result_valid),
        .swing_velocity  (swing_velocity),
        .boom_velocity   (boom_velocity),
        .arm_velocity    (arm_velocity),
        .bucket_velocity (bucket_velocity)
    );

endmodule

`default_nettype wire
